@@ hdl/arlc_pkg.sv @@
`default_nettype none

package arlc_pkg;

  // bytes of a line kept for keyword matching
  localparam int HEAD_LEN = 16;
  // clamped length used by the classifier (16 means sixteen or more)
  localparam int SLEN_W = 5;
  // width of the reported line length
  localparam int TEXT_W = 9;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_PROMPT = 8'h3E;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  typedef enum logic [3:0] {
    KIND_PROMPT   = 4'd0,
    KIND_EMPTY    = 4'd1,
    KIND_ECHO     = 4'd2,
    KIND_PLUS     = 4'd3,
    KIND_OK       = 4'd4,
    KIND_ERROR    = 4'd5,
    KIND_READY    = 4'd6,
    KIND_BUSY     = 4'd7,
    KIND_SENDOK   = 4'd8,
    KIND_SENDFAIL = 4'd9,
    KIND_WIFICONN = 4'd10,
    KIND_GOTIP    = 4'd11,
    KIND_DISCONN  = 4'd12,
    KIND_UNKNOWN  = 4'd13,
    KIND_TOOLONG  = 4'd14
  } line_kind_t;

  // what the front end hands to the classifier
  typedef enum logic [1:0] {
    REC_PROMPT = 2'd0,
    REC_LINE   = 2'd1,
    REC_LONG   = 2'd2
  } rec_tag_t;

  typedef logic [HEAD_LEN-1:0][7:0] head_t;

  typedef struct packed {
    rec_tag_t            tag;
    head_t               head;
    logic [SLEN_W-1:0]   short_len;
    logic [TEXT_W-1:0]   text_len;
  } line_rec_t;

endpackage

`default_nettype wire

@@ hdl/arlc_byte_if.sv @@
`default_nettype none

interface arlc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/arlc_line_if.sv @@
`default_nettype none

interface arlc_line_if;
  logic       valid;
  logic       ready;
  logic [3:0] line_kind;
  logic [8:0] text_length;

  modport source (output valid, output line_kind, output text_length, input ready);
  modport sink (input valid, input line_kind, input text_length, output ready);
endinterface

`default_nettype wire

@@ hdl/arlc_front.sv @@
`default_nettype none

module arlc_front #(
  parameter int MAX_LINE = 256
) (
  input  logic                clk,
  input  logic                rst,
  arlc_byte_if.sink           rx,
  input  logic                q_full,
  output logic                q_push,
  output arlc_pkg::line_rec_t q_rec
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int TW = arlc_pkg::TEXT_W;
  localparam int SW = arlc_pkg::SLEN_W;
  localparam int LW = (CW > TW) ? CW : TW;
  localparam logic [CW-1:0] LAST_POS = CW'(MAX_LINE - 1);
  localparam logic [TW-1:0] LONG_LEN = TW'(MAX_LINE % (1 << TW));

  arlc_pkg::head_t head;
  arlc_pkg::head_t head_next;
  logic [CW-1:0]   count;
  logic            cr_seen;

  logic            accept;
  logic [7:0]      b;
  logic            is_prompt;
  logic            line_end;
  logic            too_long;
  logic [LW-1:0]   len_wide;

  // no transaction is taken while reset is held
  assign rx.ready = !q_full && !rst;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // line framing decisions for the byte on the port
  assign is_prompt = (count == '0) && (b == arlc_pkg::CHAR_PROMPT);
  assign line_end  = cr_seen && (b == arlc_pkg::CHAR_LF);
  assign too_long  = !line_end && (count == LAST_POS);
  assign len_wide  = LW'(count) - LW'(1);

  // head with the new byte dropped into its slot
  always_comb begin
    for (int i = 0; i < arlc_pkg::HEAD_LEN; i++) begin
      head_next[i] = (count == CW'(i)) ? b : head[i];
    end
  end

  // record for the classifier
  always_comb begin
    q_rec.head = head_next;
    q_rec.short_len = (len_wide >= LW'(arlc_pkg::HEAD_LEN)) ? SW'(arlc_pkg::HEAD_LEN)
                                                            : len_wide[SW-1:0];
    if (is_prompt) begin
      q_rec.tag      = arlc_pkg::REC_PROMPT;
      q_rec.text_len = '0;
    end else if (line_end) begin
      q_rec.tag      = arlc_pkg::REC_LINE;
      q_rec.text_len = len_wide[TW-1:0];
    end else begin
      q_rec.tag      = arlc_pkg::REC_LONG;
      q_rec.text_len = LONG_LEN;
    end
  end

  assign q_push = accept && (is_prompt || line_end || too_long);

  // line count and cr/lf tracker
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cr_seen <= 1'b0;
    end else if (accept && !is_prompt) begin
      if (line_end || too_long) begin
        count   <= '0;
        cr_seen <= 1'b0;
      end else begin
        count   <= count + CW'(1);
        cr_seen <= !cr_seen && (b == arlc_pkg::CHAR_CR);
      end
    end
  end

  // stored head bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (accept && !is_prompt) begin
      head <= head_next;
    end
  end

`ifndef SYNTHESIS
  a_prompt_keeps_line: assert property (@(posedge clk) disable iff (rst)
    (accept && is_prompt) |=> (count == '0) && $stable(cr_seen))
    else $error("prompt disturbed line state");
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && (line_end || too_long)) |=> (count == '0) && !cr_seen)
    else $error("line not restarted after result");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) < MAX_LINE)
    else $error("line count beyond maximum");
`endif

endmodule

`default_nettype wire

@@ hdl/arlc_queue.sv @@
`default_nettype none

module arlc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  arlc_pkg::line_rec_t wr_rec,
  input  logic                pop,
  output arlc_pkg::line_rec_t rd_rec,
  output logic                full,
  output logic                empty
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVW = $clog2(DEPTH + 1);

  arlc_pkg::line_rec_t entries [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [LVW-1:0]      level;

  assign full   = (level == LVW'(DEPTH));
  assign empty  = (level == '0);
  assign rd_rec = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LVW'(1);
      end else if (pop && !push) begin
        level <= level - LVW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVW'(DEPTH))
    else $error("queue level out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/arlc_back.sv @@
`default_nettype none

module arlc_back (
  input  logic                clk,
  input  logic                rst,
  input  arlc_pkg::line_rec_t rec,
  input  logic                q_empty,
  output logic                q_pop,
  arlc_line_if.source         tx
);

  localparam int SW = arlc_pkg::SLEN_W;
  localparam int TW = arlc_pkg::TEXT_W;

  logic                   out_valid;
  arlc_pkg::line_kind_t   kind;
  logic [TW-1:0]          text_len;
  arlc_pkg::line_kind_t   kind_next;

  // first n bytes from off equal the keyword, all within the line and the head
  function automatic logic has_prefix(arlc_pkg::head_t h, logic [SW-1:0] sl,
                                      int off, int n, logic [79:0] s);
    logic ok;
    ok = (32'(sl) >= off + n) && (off + n <= arlc_pkg::HEAD_LEN);
    for (int i = 0; i < 10; i++) begin
      if (i < n) begin
        if (h[4'(off + i)] != s[8*(n-1-i) +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // keyword ends the text: line end or a zero byte right after it
  function automatic logic is_text(arlc_pkg::head_t h, logic [SW-1:0] sl,
                                   int off, int n, logic [79:0] s);
    logic ok;
    ok = has_prefix(h, sl, off, n, s);
    return ok && ((32'(sl) == off + n) ||
                  ((off + n < arlc_pkg::HEAD_LEN) && (h[4'(off + n)] == arlc_pkg::CHAR_NUL)));
  endfunction

  // keyword classification in fixed priority order
  always_comb begin
    priority if (rec.tag == arlc_pkg::REC_PROMPT) begin
      kind_next = arlc_pkg::KIND_PROMPT;
    end else if (rec.tag != arlc_pkg::REC_LINE) begin
      kind_next = arlc_pkg::KIND_TOOLONG;
    end else if (rec.short_len == '0) begin
      kind_next = arlc_pkg::KIND_EMPTY;
    end else if (rec.short_len > SW'(2) && has_prefix(rec.head, rec.short_len, 0, 2, "AT")) begin
      kind_next = arlc_pkg::KIND_ECHO;
    end else if (rec.head[0] == arlc_pkg::CHAR_PLUS) begin
      kind_next = arlc_pkg::KIND_PLUS;
    end else if (is_text(rec.head, rec.short_len, 0, 2, "OK")) begin
      kind_next = arlc_pkg::KIND_OK;
    end else if (is_text(rec.head, rec.short_len, 0, 5, "ERROR")) begin
      kind_next = arlc_pkg::KIND_ERROR;
    end else if (is_text(rec.head, rec.short_len, 0, 5, "ready")) begin
      kind_next = arlc_pkg::KIND_READY;
    end else if (has_prefix(rec.head, rec.short_len, 0, 4, "busy")) begin
      kind_next = arlc_pkg::KIND_BUSY;
    end else if (rec.short_len >= SW'(7) &&
                 has_prefix(rec.head, rec.short_len, 0, 5, "SEND ")) begin
      if (is_text(rec.head, rec.short_len, 5, 2, "OK")) begin
        kind_next = arlc_pkg::KIND_SENDOK;
      end else if (is_text(rec.head, rec.short_len, 5, 4, "FAIL")) begin
        kind_next = arlc_pkg::KIND_SENDFAIL;
      end else begin
        kind_next = arlc_pkg::KIND_UNKNOWN;
      end
    end else if (rec.short_len >= SW'(11) &&
                 has_prefix(rec.head, rec.short_len, 0, 5, "WIFI ")) begin
      if (is_text(rec.head, rec.short_len, 5, 9, "CONNECTED")) begin
        kind_next = arlc_pkg::KIND_WIFICONN;
      end else if (is_text(rec.head, rec.short_len, 5, 6, "GOT IP")) begin
        kind_next = arlc_pkg::KIND_GOTIP;
      end else if (is_text(rec.head, rec.short_len, 5, 10, "DISCONNECT")) begin
        kind_next = arlc_pkg::KIND_DISCONN;
      end else begin
        kind_next = arlc_pkg::KIND_UNKNOWN;
      end
    end else begin
      kind_next = arlc_pkg::KIND_UNKNOWN;
    end
  end

  // take a record whenever the output register is free or draining
  assign q_pop = !q_empty && (!out_valid || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind     <= kind_next;
      text_len <= rec.text_len;
    end
  end

  assign tx.valid       = out_valid;
  assign tx.line_kind   = kind;
  assign tx.text_length = text_len;

`ifndef SYNTHESIS
  a_pop_fills: assert property (@(posedge clk) disable iff (rst) q_pop |=> out_valid)
    else $error("popped record not presented");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx.ready) |-> !q_pop)
    else $error("record popped over a stalled result");
  a_prompt_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == arlc_pkg::KIND_PROMPT) |-> (text_len == '0))
    else $error("prompt with nonzero length");
`endif

endmodule

`default_nettype wire

@@ hdl/at_response_line_classifier_core.sv @@
// Modem response line classifier.
// rx channel: one received byte per transaction (rx_byte).
// tx channel: one result per finished line or prompt: line_kind and
//   text_length (length without CR LF; 0 for a prompt; MAX_LINE modulo 512
//   for a line that hit MAX_LINE bytes without CR LF).
// A '>' as the first byte of a line gives a prompt result at once; any
// other byte is added to the line, and CR LF or MAX_LINE bytes closes it.
// Throughput: one byte per cycle. The front end frames the line in the
// accepting cycle and pushes a record into a QUEUE_DEPTH-entry queue; the
// back end classifies the queue head against the 16 stored head bytes and
// registers the result.
// Result path: the record is registered in the queue, and the back end
// pops it into the output register, which drives tx.valid.
// Stall: while tx.ready is low the output register holds its result and
// the queue fills; once it is full rx.ready drops until tx drains.
// Reset (synchronous, rst high): empties the queue, drops tx.valid and
// starts a fresh line; rx.ready is held low while rst is high.
`default_nettype none

module at_response_line_classifier_core #(
  parameter int MAX_LINE    = 256,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  arlc_byte_if.sink   rx,
  arlc_line_if.source tx
);

  arlc_pkg::line_rec_t push_rec;
  arlc_pkg::line_rec_t head_rec;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  // line framing
  arlc_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (push_rec)
  );

  // decoupling queue
  arlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (push_rec),
    .pop    (q_pop),
    .rd_rec (head_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  // keyword classification and result register
  arlc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rec     (head_rec),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .tx      (tx)
  );

endmodule

`default_nettype wire

@@ dv/tb_at_response_line_classifier_core.sv @@
`default_nettype none

module tb_at_response_line_classifier_core;

  localparam int LINE_MAX    = 256;
  localparam int IDLE_PCT    = 37;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_BYTES = 1200;

  typedef struct {
    arlc_pkg::line_kind_t kind;
    logic [8:0]           len;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arlc_byte_if rx_bus ();
  arlc_line_if tx_bus ();

  at_response_line_classifier_core #(
    .MAX_LINE(LINE_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rx (rx_bus.sink),
    .tx (tx_bus.source)
  );

  // clock
  always #10 clk = ~clk;

  // bytes waiting to be sent and line results waiting to arrive
  logic [7:0]   rx_bytes[$];
  line_result_t line_results[$];
  line_result_t oldest;

  // predicted line framing state
  logic [7:0]  head_buf[arlc_pkg::HEAD_LEN];
  int unsigned line_bytes;
  int unsigned crlf_state;

  // run control and bookkeeping
  logic        byte_taken = 1'b0;
  bit          calm = 1'b0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          err_count = 0;
  int          bytes_taken = 0;
  int          results_seen = 0;
  int          kind_seen[15];
  int          queued_bytes = 0;
  int          cycle_cnt = 0;
  string       kinds_str;

  string reply_words[20] = '{
    "OK", "ERROR", "ready", "busy p...", "SEND OK", "SEND FAIL",
    "WIFI CONNECTED", "WIFI GOT IP", "WIFI DISCONNECT", "AT+CWMODE=1",
    "+IPD,4:abcd", "AT", "", "no change", "SEND ", "WIFI ",
    "link is not valid", "+", "ATE0", "WIFI DISCONNECTED"
  };

  // line starts with s at offset off
  function automatic bit head_prefix(string s, int unsigned off, int unsigned len);
    int unsigned n;
    n = s.len();
    if (len < off + n || off + n > arlc_pkg::HEAD_LEN) return 1'b0;
    for (int i = 0; i < n; i++)
      if (head_buf[off + i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  // text from off up to the first zero or the line end equals s
  function automatic bit head_word(string s, int unsigned off, int unsigned len);
    int unsigned stop;
    stop = off + s.len();
    if (!head_prefix(s, off, len)) return 1'b0;
    if (len == stop) return 1'b1;
    return stop < arlc_pkg::HEAD_LEN && head_buf[stop] == arlc_pkg::CHAR_NUL;
  endfunction

  function automatic arlc_pkg::line_kind_t classify_line(int unsigned len);
    if (len == 0) return arlc_pkg::KIND_EMPTY;
    if (len > 2 && head_prefix("AT", 0, len)) return arlc_pkg::KIND_ECHO;
    if (head_buf[0] == arlc_pkg::CHAR_PLUS) return arlc_pkg::KIND_PLUS;
    if (head_word("OK", 0, len)) return arlc_pkg::KIND_OK;
    if (head_word("ERROR", 0, len)) return arlc_pkg::KIND_ERROR;
    if (head_word("ready", 0, len)) return arlc_pkg::KIND_READY;
    if (head_prefix("busy", 0, len)) return arlc_pkg::KIND_BUSY;
    if (len >= 7 && head_prefix("SEND ", 0, len)) begin
      if (head_word("OK", 5, len)) return arlc_pkg::KIND_SENDOK;
      if (head_word("FAIL", 5, len)) return arlc_pkg::KIND_SENDFAIL;
      return arlc_pkg::KIND_UNKNOWN;
    end
    if (len >= 11 && head_prefix("WIFI ", 0, len)) begin
      if (head_word("CONNECTED", 5, len)) return arlc_pkg::KIND_WIFICONN;
      if (head_word("GOT IP", 5, len)) return arlc_pkg::KIND_GOTIP;
      if (head_word("DISCONNECT", 5, len)) return arlc_pkg::KIND_DISCONN;
      return arlc_pkg::KIND_UNKNOWN;
    end
    return arlc_pkg::KIND_UNKNOWN;
  endfunction

  // frame one received byte and queue the line result it closes, if any
  function automatic void absorb_rx_byte(logic [7:0] b);
    logic [7:0]  want;
    int unsigned len;
    if (line_bytes == 0 && b == arlc_pkg::CHAR_PROMPT) begin
      line_results.push_back('{arlc_pkg::KIND_PROMPT, 9'd0});
      return;
    end
    if (line_bytes < arlc_pkg::HEAD_LEN) head_buf[line_bytes] = b;
    want = (crlf_state == 0) ? arlc_pkg::CHAR_CR : arlc_pkg::CHAR_LF;
    // a mismatch clears the tracker and is not retried as a CR
    if (b == want) crlf_state++;
    else crlf_state = 0;
    line_bytes++;
    if (crlf_state >= 2) begin
      len = line_bytes - 2;
      line_results.push_back('{classify_line(len), 9'(len)});
      line_bytes = 0;
      crlf_state = 0;
    end else if (line_bytes >= LINE_MAX) begin
      line_results.push_back('{arlc_pkg::KIND_TOOLONG, 9'(LINE_MAX)});
      line_bytes = 0;
      crlf_state = 0;
    end
  endfunction

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) rx_bytes.push_back(s[i]);
    queued_bytes += s.len();
  endtask

  task automatic queue_fill(int n, logic [7:0] b);
    for (int i = 0; i < n; i++) rx_bytes.push_back(b);
    queued_bytes += n;
  endtask

  // one random line: mostly well-formed replies, some noise and broken endings
  task automatic queue_random_line();
    int         pick;
    int         n;
    int         pos;
    logic [7:0] b;
    logic [7:0] line_q[$];
    string      word;
    pick = $urandom_range(99);
    if (pick < 6) begin
      line_q.push_back(arlc_pkg::CHAR_PROMPT);
    end else if (pick < 14) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0: line_q.push_back(arlc_pkg::CHAR_CR);
          1: line_q.push_back(arlc_pkg::CHAR_LF);
          2: line_q.push_back(arlc_pkg::CHAR_PROMPT);
          3: line_q.push_back(arlc_pkg::CHAR_NUL);
          default: line_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end else if (pick < 15) begin
      // long line, rarely hitting or just missing the length limit
      n = $urandom_range(250, 262);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        line_q.push_back((b == arlc_pkg::CHAR_CR) ? 8'h20 : b);
      end
      if ($urandom_range(1) == 1) begin
        line_q.push_back(arlc_pkg::CHAR_CR);
        line_q.push_back(arlc_pkg::CHAR_LF);
      end
    end else begin
      word = reply_words[$urandom_range(19)];
      for (int i = 0; i < word.len(); i++) line_q.push_back(word[i]);
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(3))
          0: if (line_q.size() != 0) begin
            pos = $urandom_range(line_q.size() - 1);
            line_q[pos] = 8'($urandom_range(255));
          end
          1: begin
            line_q.push_back(arlc_pkg::CHAR_NUL);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) line_q.push_back(8'($urandom_range(255)));
          end
          2: begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) line_q.push_back(8'($urandom_range(32, 126)));
          end
          default: if (line_q.size() != 0) void'(line_q.pop_back());
        endcase
      end
      // broken endings now and then, otherwise a proper CR LF
      case (pick < 20 ? $urandom_range(2) : 3)
        0: begin
          line_q.push_back(arlc_pkg::CHAR_CR);
          line_q.push_back(arlc_pkg::CHAR_CR);
          line_q.push_back(arlc_pkg::CHAR_LF);
        end
        1: line_q.push_back(arlc_pkg::CHAR_LF);
        2: line_q.push_back(arlc_pkg::CHAR_CR);
        default: begin
          line_q.push_back(arlc_pkg::CHAR_CR);
          line_q.push_back(arlc_pkg::CHAR_LF);
        end
      endcase
    end
    queued_bytes += line_q.size();
    foreach (line_q[i]) rx_bytes.push_back(line_q[i]);
  endtask

  // hold the sender until every queued byte is taken and every result is back
  task automatic wait_lines_drained();
    while (rx_bytes.size() != 0 || rx_bus.valid || line_results.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // byte source
  always @(negedge clk) begin
    if (rst) begin
      rx_bus.valid <= 1'b0;
    end else if (!rx_bus.valid || byte_taken) begin
      if (rx_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= rx_bytes.pop_front();
      end else begin
        rx_bus.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      tx_bus.ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack     <= hold_req;
      hold_left    <= LONG_HOLD;
      tx_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      tx_bus.ready <= 1'b0;
    end else begin
      tx_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: check results against the oldest prediction, then predict
  always @(posedge clk) begin
    if (!rst) begin
      if (tx_bus.valid && tx_bus.ready) begin
        results_seen++;
        if (line_results.size() == 0) begin
          $error("unexpected result: line_kind %0d text_length %0d",
                 tx_bus.line_kind, tx_bus.text_length);
          err_count++;
        end else begin
          oldest = line_results.pop_front();
          kind_seen[oldest.kind]++;
          if (tx_bus.line_kind !== oldest.kind) begin
            $error("line_kind: expected %0d, got %0d", oldest.kind, tx_bus.line_kind);
            err_count++;
          end
          if (tx_bus.text_length !== oldest.len) begin
            $error("text_length: expected %0d, got %0d", oldest.len, tx_bus.text_length);
            err_count++;
          end
        end
      end
      if (rx_bus.valid && rx_bus.ready) begin
        bytes_taken++;
        absorb_rx_byte(rx_bus.rx_byte);
      end
    end
    byte_taken <= !rst && rx_bus.valid && rx_bus.ready;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    tx_bus.ready   = 1'b0;
    line_bytes     = 0;
    crlf_state     = 0;
    foreach (head_buf[i]) head_buf[i] = 8'h00;
    foreach (kind_seen[i]) kind_seen[i] = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every kind, byte extremes and the framing corner cases
    queue_text(">");
    queue_text("\r\n");
    queue_text("ATE0\r\n");
    queue_text("AT\r\n");
    queue_text("+CIFSR:STAIP\r\n");
    queue_text("OK\r\n");
    queue_text("ERROR\r\n");
    queue_text("ready\r\n");
    queue_text("busy s...\r\n");
    queue_text("SEND OK\r\n");
    queue_text("SEND FAIL\r\n");
    queue_text("SEND OKAY\r\n");
    queue_text("WIFI CONNECTED\r\n");
    queue_text("WIFI GOT IP\r\n");
    queue_text("WIFI DISCONNECT\r\n");
    queue_text("WIFI DISCONNECTED\r\n");
    // zero byte right after a keyword, and bare extremes
    queue_text("OK");
    queue_fill(1, arlc_pkg::CHAR_NUL);
    queue_text("junk\r\n");
    queue_fill(1, 8'hFF);
    queue_fill(1, arlc_pkg::CHAR_NUL);
    queue_text("\r\n");
    // prompt char mid-line is plain text; CR CR LF does not close a line
    queue_text("O>K\r\n");
    queue_text("\r\r\nOK\r\n");
    // length limit hit, then a prompt on the fresh line
    queue_fill(LINE_MAX, 8'hA5);
    queue_text(">");
    // CR LF landing exactly on the limit
    queue_fill(LINE_MAX - 2, 8'h78);
    queue_text("\r\n");
    // limit hit with a CR as the last byte, the LF then opens a new line
    queue_fill(LINE_MAX - 1, 8'h79);
    queue_text("\r\nOK\r\n");
    wait_lines_drained();

    // receiver holds off while the sender keeps offering random lines
    hold_req = hold_req + 1;
    for (int i = 0; i < 8; i++) queue_random_line();
    wait_lines_drained();

    // no idling on either side for a while
    calm = 1'b1;
    for (int i = 0; i < 10; i++) queue_random_line();
    wait_lines_drained();
    calm = 1'b0;

    // bulk random traffic
    while (queued_bytes < TOTAL_BYTES) queue_random_line();
    queue_text("\r\n");
    wait_lines_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    kinds_str = "";
    foreach (kind_seen[k]) kinds_str = {kinds_str, $sformatf(" %0d", kind_seen[k])};
    $display("covered %0d received bytes and %0d line results", bytes_taken, results_seen);
    $display("results per kind, prompt through too-long:%s", kinds_str);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/arlc_pkg.sv
hdl/arlc_byte_if.sv
hdl/arlc_line_if.sv
hdl/arlc_front.sv
hdl/arlc_queue.sv
hdl/arlc_back.sv
hdl/at_response_line_classifier_core.sv
dv/tb_at_response_line_classifier_core.sv
